FILE: hw/rtl/frp_pkg.sv
package frp_pkg;

   localparam int LEN_W    = 32;
   localparam int RADIX_W  = 32;
   localparam int STAGE_W  = 3;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_LENGTH_BITS = 32;
   localparam int DEF_MAX_STAGES  = 5;
   localparam int DEF_MAX_FACTORS = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_MIN    = 1'd1;

   localparam logic [CSR_W-1:0] MERGE_LIMIT_RST = 16'd32;
   localparam logic [CSR_W-1:0] LEAD_MIN_RST    = 16'd16;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_CHK,
      ST_DIV,
      ST_DIVEND,
      ST_TAIL,
      ST_PK_START,
      ST_PK_RD,
      ST_PK_EV,
      ST_PK_END,
      ST_SEL_START,
      ST_SEL_RD,
      ST_SEL_EV,
      ST_SEL_END,
      ST_FOLD,
      ST_SORT,
      ST_LEAD,
      ST_OUT,
      ST_ERR
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_DIV_END,
      OP_TAIL,
      OP_PK_START,
      OP_PK_RD,
      OP_PK_EV,
      OP_PK_END,
      OP_SEL_START,
      OP_SEL_RD,
      OP_SEL_EV,
      OP_SEL_END,
      OP_FOLD,
      OP_SORT,
      OP_LEAD,
      OP_OUT_NEXT
   } dp_op_type;

   typedef struct packed {
      logic len_small;
      logic sq_le;
      logic np_room;
      logic div_last;
      logic rem_zero;
      logic pk_last;
      logic prod_one;
      logic sel_last;
      logic sel_is_max;
      logic ext_final;
      logic ext_done;
      logic sort_last;
      logic out_last;
   } sts_type;

endpackage

FILE: hw/rtl/frp_req_if.sv
interface frp_req_if import frp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] length;

   modport source (output valid, output length, input ready);
   modport sink (input valid, input length, output ready);
endinterface

FILE: hw/rtl/frp_rsp_if.sv
interface frp_rsp_if import frp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RADIX_W-1:0] radix;
   logic [STAGE_W-1:0] stage_index;
   logic               last;
   logic               error;

   modport source (output valid, output radix, output stage_index, output last,
                   output error, input ready);
   modport sink (input valid, input radix, input stage_index, input last,
                 input error, output ready);
endinterface

FILE: hw/rtl/frp_ctrl.sv
module frp_ctrl import frp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  sts_type   sts,
   input  logic      req_valid,
   input  logic      rsp_ready,
   output dp_op_type op,
   output logic      req_ready,
   output logic      rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = sts.len_small ? ST_ERR : ST_SQ;
            end
         end
         ST_SQ: begin
            op       = OP_SQ;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sts.sq_le && sts.np_room) begin
               op       = OP_DIV_START;
               state_in = ST_DIV;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_DIV: begin
            op = OP_DIV_STEP;
            if (sts.div_last) state_in = ST_DIVEND;
         end
         ST_DIVEND: begin
            op       = OP_DIV_END;
            state_in = ST_SQ;
         end
         ST_TAIL: begin
            op       = OP_TAIL;
            state_in = ST_PK_START;
         end
         ST_PK_START: begin
            op       = OP_PK_START;
            state_in = ST_PK_RD;
         end
         ST_PK_RD: begin
            op       = OP_PK_RD;
            state_in = ST_PK_EV;
         end
         ST_PK_EV: begin
            op       = OP_PK_EV;
            state_in = sts.pk_last ? ST_PK_END : ST_PK_RD;
         end
         ST_PK_END: begin
            op       = OP_PK_END;
            state_in = sts.prod_one ? ST_SEL_START : ST_PK_START;
         end
         ST_SEL_START: begin
            op       = OP_SEL_START;
            state_in = ST_SEL_RD;
         end
         ST_SEL_RD: begin
            op       = OP_SEL_RD;
            state_in = ST_SEL_EV;
         end
         ST_SEL_EV: begin
            op       = OP_SEL_EV;
            state_in = sts.sel_last ? ST_SEL_END : ST_SEL_RD;
         end
         ST_SEL_END: begin
            op = OP_SEL_END;
            if (!sts.sel_is_max) state_in = ST_FOLD;
            else if (sts.ext_final) state_in = ST_SORT;
            else state_in = ST_SEL_START;
         end
         ST_FOLD: begin
            op       = OP_FOLD;
            state_in = sts.ext_done ? ST_SORT : ST_SEL_START;
         end
         ST_SORT: begin
            op = OP_SORT;
            if (sts.sort_last) state_in = ST_LEAD;
         end
         ST_LEAD: begin
            op       = OP_LEAD;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               op = OP_OUT_NEXT;
               if (sts.out_last) state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/frp_dpath.sv
module frp_dpath import frp_pkg::*; #(
   parameter int LENGTH_BITS = DEF_LENGTH_BITS,
   parameter int MAX_STAGES  = DEF_MAX_STAGES,
   parameter int MAX_FACTORS = DEF_MAX_FACTORS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_op_type            op,
   input  logic [LEN_W-1:0]     req_length,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output sts_type              sts,
   output logic [RADIX_W-1:0]   rsp_radix,
   output logic [STAGE_W-1:0]   rsp_stage_index,
   output logic                 rsp_last,
   output logic                 rsp_error
);

   localparam int VW  = (LENGTH_BITS > RADIX_W) ? RADIX_W : LENGTH_BITS;
   localparam int DW  = (VW + 1) / 2 + 1;
   localparam int FIW = $clog2(MAX_FACTORS);
   localparam int FCW = $clog2(MAX_FACTORS + 1);
   localparam int SIW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int SCW = $clog2(MAX_STAGES + 1);
   localparam int DCW = $clog2(VW);

   logic [CSR_W-1:0]  merge_ff, lead_ff;
   logic [VW-1:0]     rest_ff;
   logic [DW-1:0]     d_ff;
   logic [2*DW-1:0]   sq_ff;
   logic [DW-1:0]     rem_ff;
   logic [VW-1:0]     quo_ff;
   logic [DCW-1:0]    dcnt_ff;
   logic [FCW-1:0]    np_ff, ng_ff, ext_ff;
   logic [FIW-1:0]    j_ff, bi_ff;
   logic [MAX_FACTORS-1:0] used_ff, taken_ff;
   logic [VW-1:0]     prod_ff, best_ff;
   logic              best_ok_ff;
   logic [VW-1:0]     top_ff [MAX_STAGES];
   logic [SCW-1:0]    pass_ff;
   logic [SIW-1:0]    oi_ff;
   logic              err_ff;

   logic [VW-1:0]     prime_mem [MAX_FACTORS];
   logic [VW-1:0]     group_mem [MAX_FACTORS];
   logic [VW-1:0]     prime_rd_ff, group_rd_ff;

   logic              len_small_c;
   logic [2*DW-1:0]   sq_c;
   logic [DW:0]       rem2_c;
   logic              ge_c;
   logic [DW:0]       remd_c;
   logic [2*VW-1:0]   pp_c;
   logic              fits_c;
   logic [SCW-1:0]    ntop_c;
   logic [SCW-1:0]    slot_c;
   logic              cand_c;
   logic [SIW-1:0]    argmin_c;
   logic [2*VW-1:0]   fp_c;
   logic [VW-1:0]     sorted_c [MAX_STAGES];
   logic              lead_hit_c;
   logic [SIW-1:0]    lead_idx_c;
   logic              prime_we_c;
   logic [VW-1:0]     prime_wd_c;
   logic [FIW-1:0]    prime_ra_c;

   assign len_small_c = req_length[VW-1:0] <= VW'(1);
   assign sq_c   = (2*DW)'(d_ff) * (2*DW)'(d_ff);
   assign rem2_c = {rem_ff, quo_ff[VW-1]};
   assign ge_c   = rem2_c >= {1'b0, d_ff};
   assign remd_c = ge_c ? rem2_c - {1'b0, d_ff} : rem2_c;
   assign pp_c   = (2*VW)'(prime_rd_ff) * (2*VW)'(prod_ff);
   assign fits_c = (prod_ff == VW'(1)) || (pp_c <= (2*VW)'(merge_ff));
   assign ntop_c = (ng_ff > FCW'(MAX_STAGES)) ? SCW'(MAX_STAGES) : SCW'(ng_ff);
   assign slot_c = ntop_c - SCW'(1) - SCW'(ext_ff);
   assign cand_c = !taken_ff[j_ff] && (!best_ok_ff ||
                   (sts.sel_is_max ? (group_rd_ff > best_ff) : (group_rd_ff < best_ff)));
   assign fp_c   = (2*VW)'(top_ff[argmin_c]) * (2*VW)'(best_ff);
   assign prime_ra_c = FIW'(np_ff - FCW'(1) - FCW'(j_ff));

   always_comb begin
      int m;
      m = 0;
      for (int i = 1; i < MAX_STAGES; i++) begin
         if (top_ff[i] < top_ff[m]) m = i;
      end
      argmin_c = SIW'(m);
   end

   // one odd-even transposition pass over the live slots
   always_comb begin
      for (int i = 0; i < MAX_STAGES; i++) sorted_c[i] = top_ff[i];
      for (int i = 0; i + 1 < MAX_STAGES; i++) begin
         if ((i % 2) == int'(pass_ff[0]) && SCW'(i + 1) < ntop_c &&
             top_ff[i] > top_ff[i+1]) begin
            sorted_c[i]   = top_ff[i+1];
            sorted_c[i+1] = top_ff[i];
         end
      end
   end

   always_comb begin
      lead_hit_c = 1'b0;
      lead_idx_c = '0;
      for (int i = MAX_STAGES - 1; i >= 1; i--) begin
         if (SCW'(i) < ntop_c && RADIX_W'(top_ff[i]) >= RADIX_W'(lead_ff)) begin
            lead_hit_c = 1'b1;
            lead_idx_c = SIW'(i);
         end
      end
   end

   always_comb begin
      prime_we_c = 1'b0;
      prime_wd_c = rest_ff;
      if (op == OP_DIV_END && rem_ff == '0) begin
         prime_we_c = 1'b1;
         prime_wd_c = VW'(d_ff);
      end else if (op == OP_TAIL && rest_ff != VW'(1)) begin
         prime_we_c = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (prime_we_c) prime_mem[FIW'(np_ff)] <= prime_wd_c;
      if (op == OP_PK_END && prod_ff != VW'(1)) group_mem[FIW'(ng_ff)] <= prod_ff;
      prime_rd_ff <= prime_mem[prime_ra_c];
      group_rd_ff <= group_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ff <= MERGE_LIMIT_RST;
         lead_ff  <= LEAD_MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MERGE_LIMIT: merge_ff <= csr_wdata;
            CSR_LEAD_MIN:    lead_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff       <= DW'(2);
         dcnt_ff    <= '0;
         np_ff      <= '0;
         ng_ff      <= '0;
         ext_ff     <= '0;
         j_ff       <= '0;
         best_ok_ff <= 1'b0;
         pass_ff    <= '0;
         oi_ff      <= '0;
         err_ff     <= 1'b0;
         used_ff    <= '0;
         taken_ff   <= '0;
      end else begin
         case (op)
            OP_LOAD: begin
               rest_ff <= req_length[VW-1:0];
               d_ff    <= DW'(2);
               np_ff   <= '0;
               ng_ff   <= '0;
               ext_ff  <= '0;
               oi_ff   <= '0;
               err_ff  <= len_small_c;
            end
            OP_SQ: sq_ff <= sq_c;
            OP_DIV_START: begin
               rem_ff  <= '0;
               quo_ff  <= rest_ff;
               dcnt_ff <= '0;
            end
            OP_DIV_STEP: begin
               rem_ff  <= remd_c[DW-1:0];
               quo_ff  <= {quo_ff[VW-2:0], ge_c};
               dcnt_ff <= dcnt_ff + DCW'(1);
            end
            OP_DIV_END: begin
               if (rem_ff == '0) begin
                  np_ff   <= np_ff + FCW'(1);
                  rest_ff <= quo_ff;
               end else begin
                  d_ff <= d_ff + DW'(1);
               end
            end
            OP_TAIL: begin
               if (rest_ff != VW'(1)) np_ff <= np_ff + FCW'(1);
               ng_ff    <= '0;
               ext_ff   <= '0;
               used_ff  <= '0;
               taken_ff <= '0;
            end
            OP_PK_START: begin
               prod_ff <= VW'(1);
               j_ff    <= '0;
            end
            OP_PK_EV: begin
               if (!used_ff[j_ff] && fits_c) begin
                  prod_ff        <= pp_c[VW-1:0];
                  used_ff[j_ff]  <= 1'b1;
               end
               j_ff <= j_ff + FIW'(1);
            end
            OP_PK_END: begin
               if (prod_ff != VW'(1)) ng_ff <= ng_ff + FCW'(1);
            end
            OP_SEL_START: begin
               best_ok_ff <= 1'b0;
               j_ff       <= '0;
               pass_ff    <= '0;
            end
            OP_SEL_EV: begin
               if (cand_c) begin
                  best_ff    <= group_rd_ff;
                  bi_ff      <= j_ff;
                  best_ok_ff <= 1'b1;
               end
               j_ff <= j_ff + FIW'(1);
            end
            OP_SEL_END: begin
               taken_ff[bi_ff] <= 1'b1;
               ext_ff <= ext_ff + FCW'(1);
               if (sts.sel_is_max) top_ff[slot_c[SIW-1:0]] <= best_ff;
            end
            OP_FOLD: top_ff[argmin_c] <= fp_c[VW-1:0];
            OP_SORT: begin
               top_ff  <= sorted_c;
               pass_ff <= pass_ff + SCW'(1);
            end
            OP_LEAD: begin
               oi_ff <= '0;
               if (ntop_c > SCW'(1) && RADIX_W'(top_ff[0]) < RADIX_W'(lead_ff) &&
                   lead_hit_c) begin
                  top_ff[0]          <= top_ff[lead_idx_c];
                  top_ff[lead_idx_c] <= top_ff[0];
               end
            end
            OP_OUT_NEXT: oi_ff <= oi_ff + SIW'(1);
            default: ;
         endcase
      end
   end

   always_comb begin
      sts.len_small  = len_small_c;
      sts.sq_le      = sq_ff <= (2*DW)'(rest_ff);
      sts.np_room    = np_ff < FCW'(MAX_FACTORS - 1);
      sts.div_last   = dcnt_ff == DCW'(VW - 1);
      sts.rem_zero   = rem_ff == '0;
      sts.pk_last    = FCW'(j_ff) == np_ff - FCW'(1);
      sts.prod_one   = prod_ff == VW'(1);
      sts.sel_last   = FCW'(j_ff) == ng_ff - FCW'(1);
      sts.sel_is_max = ext_ff < FCW'(ntop_c);
      sts.ext_final  = ext_ff == ng_ff - FCW'(1);
      sts.ext_done   = ext_ff == ng_ff;
      sts.sort_last  = pass_ff == SCW'(MAX_STAGES - 1);
      sts.out_last   = SCW'(oi_ff) == ntop_c - SCW'(1);
   end

   assign rsp_radix       = err_ff ? '0 : RADIX_W'(top_ff[oi_ff]);
   assign rsp_stage_index = STAGE_W'(oi_ff);
   assign rsp_last        = err_ff || sts.out_last;
   assign rsp_error       = err_ff;

   a_np_bound: assert property (@(posedge clock) disable iff (reset)
      np_ff <= FCW'(MAX_FACTORS))
      else $error("factor count overflow");

   a_ext_bound: assert property (@(posedge clock) disable iff (reset)
      ext_ff <= ng_ff)
      else $error("more extractions than groups");

   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      op == OP_DIV_END && rem_ff != '0 |=> d_ff == $past(d_ff) + DW'(1))
      else $error("divisor did not advance");

endmodule

FILE: hw/rtl/fft_radix_planner.sv
// trial division tries divisors up to the square root of the remaining cofactor, one
// quotient bit per cycle in the shared divider; packing and group selection then run
// over the factor and group memories, and results follow one per cycle while the
// receiver is ready
// throughput: one length at a time; the next request is taken after the last result
// reset: synchronous, merge_limit back to 32, lead_min back to 16, controller idle
module fft_radix_planner import frp_pkg::*; #(
   parameter int LENGTH_BITS = DEF_LENGTH_BITS,
   parameter int MAX_STAGES  = DEF_MAX_STAGES,
   parameter int MAX_FACTORS = DEF_MAX_FACTORS
) (
   input  logic                 clock,
   input  logic                 reset,
   frp_req_if.sink              req_ch,
   frp_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   dp_op_type op;
   sts_type   sts;

   frp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .op        (op),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid)
   );

   frp_dpath #(
      .LENGTH_BITS (LENGTH_BITS),
      .MAX_STAGES  (MAX_STAGES),
      .MAX_FACTORS (MAX_FACTORS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .req_length      (req_ch.length),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .sts             (sts),
      .rsp_radix       (rsp_ch.radix),
      .rsp_stage_index (rsp_ch.stage_index),
      .rsp_last        (rsp_ch.last),
      .rsp_error       (rsp_ch.error)
   );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
   import frp_pkg::*;

   typedef struct {
      logic [RADIX_W-1:0] radix;
      logic [STAGE_W-1:0] stage_index;
      logic               last;
      logic               error;
   } stage_type;

   typedef struct {
      logic [LEN_W-1:0]   length;
      bit                 typed;
      logic [RADIX_W-1:0] radix;
      bit                 error;
   } plan_row_type;

   localparam int MAX_ST   = DEF_MAX_STAGES;
   localparam int MAX_FAC  = DEF_MAX_FACTORS;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int N_ROWS   = 18;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   frp_req_if req_bus ();
   frp_rsp_if rsp_bus ();

   fft_radix_planner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   longint unsigned merge_lim;
   longint unsigned lead_floor;

   stage_type    stage_q[$];
   int           mismatches;
   int           snd_idle;
   int           rcv_idle;
   int           cycles;
   plan_row_type plan_rows[N_ROWS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected stages for one length
   task automatic plan_stages(input logic [LEN_W-1:0] len);
      longint unsigned primes[MAX_FAC];
      longint unsigned desc[MAX_FAC];
      longint unsigned groups[MAX_FAC];
      longint unsigned picked[MAX_ST];
      longint unsigned rest, d, prod, t;
      bit used[MAX_FAC];
      int np, ng, nplan, i, j, m;
      stage_type s;
      np = 0;
      ng = 0;
      rest = 64'(len);
      if (rest <= 1) begin
         s.radix = '0; s.stage_index = '0; s.last = 1'b1; s.error = 1'b1;
         stage_q.insert(stage_q.size(), s);
         return;
      end
      d = 2;
      while (d * d <= rest && np < MAX_FAC - 1) begin
         if (rest % d == 0) begin
            primes[np] = d;
            np++;
            rest = rest / d;
         end else begin
            d++;
         end
      end
      if (rest != 1) begin
         primes[np] = rest;
         np++;
      end
      for (i = 0; i < np; i++) begin
         desc[i] = primes[np-1-i];
         used[i] = 1'b0;
      end
      for (i = 0; i < np; i++) begin
         prod = 1;
         for (j = i; j < np; j++) begin
            if (!used[j] && (prod == 1 || desc[j] * prod <= merge_lim)) begin
               prod = prod * desc[j];
               used[j] = 1'b1;
            end
         end
         if (prod == 1) break;
         groups[ng] = prod;
         ng++;
      end
      for (i = 1; i < ng; i++) begin
         t = groups[i];
         j = i - 1;
         while (j >= 0 && groups[j] > t) begin
            groups[j+1] = groups[j];
            j--;
         end
         groups[j+1] = t;
      end
      if (ng > MAX_ST) begin
         for (i = 0; i < MAX_ST; i++) picked[i] = groups[ng-MAX_ST+i];
         for (i = 0; i < ng - MAX_ST; i++) begin
            m = 0;
            for (j = 1; j < MAX_ST; j++) if (picked[j] < picked[m]) m = j;
            picked[m] = picked[m] * groups[i];
         end
         for (i = 1; i < MAX_ST; i++) begin
            t = picked[i];
            j = i - 1;
            while (j >= 0 && picked[j] > t) begin
               picked[j+1] = picked[j];
               j--;
            end
            picked[j+1] = t;
         end
         nplan = MAX_ST;
      end else begin
         for (i = 0; i < ng; i++) picked[i] = groups[i];
         nplan = ng;
      end
      if (nplan > 1 && picked[0] < lead_floor) begin
         for (i = 1; i < nplan; i++) begin
            if (picked[i] >= lead_floor) begin
               t = picked[0];
               picked[0] = picked[i];
               picked[i] = t;
               break;
            end
         end
      end
      for (i = 0; i < nplan; i++) begin
         s.radix = picked[i][RADIX_W-1:0];
         s.stage_index = i[STAGE_W-1:0];
         s.last = (i == nplan - 1);
         s.error = 1'b0;
         stage_q.insert(stage_q.size(), s);
      end
   endtask

   // mostly smooth lengths so trial division stays short
   function automatic logic [LEN_W-1:0] random_length();
      int unsigned small_primes[18] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                        47, 53, 59, 61};
      int unsigned big_primes[7] = '{127, 251, 509, 1021, 2039, 4093, 8191};
      longint unsigned p, q;
      int n;
      if ($urandom_range(9) == 0) return $urandom_range(0, 5000);
      p = 1;
      if ($urandom_range(2) == 0) p = 64'(big_primes[$urandom_range(6)]);
      n = $urandom_range(1, 30);
      repeat (n) begin
         q = 64'(small_primes[$urandom_range($urandom_range(1) ? 3 : 17)]);
         if (p * q <= 64'hFFFF_FFFF) p = p * q;
      end
      return p[LEN_W-1:0];
   endfunction

   task automatic send_length(input logic [LEN_W-1:0] len, input bit typed,
                              input logic [RADIX_W-1:0] radix, input bit err);
      stage_type s;
      while ($urandom_range(99) < snd_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.length <= len;
      do @(posedge clock); while (!req_bus.ready);
      if (typed) begin
         s.radix = radix; s.stage_index = '0; s.last = 1'b1; s.error = err;
         stage_q.insert(stage_q.size(), s);
      end else begin
         plan_stages(len);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_MERGE_LIMIT) merge_lim = 64'(val);
      else if (idx == CSR_LEAD_MIN) lead_floor = 64'(val);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (stage_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(input logic [CSR_W-1:0] ml, input logic [CSR_W-1:0] lm,
                               input int s_idle, input int r_idle, input int count);
      write_csr(CSR_MERGE_LIMIT, ml);
      write_csr(CSR_LEAD_MIN, lm);
      csr_we   <= 1'b0;
      snd_idle = s_idle;
      rcv_idle = r_idle;
      repeat (count) send_length(random_length(), 1'b0, '0, 1'b0);
      drain();
   endtask

   // response checker
   always @(posedge clock) begin
      stage_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (stage_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected stage: radix %0d index %0d", rsp_bus.radix,
                           rsp_bus.stage_index);
            end else begin
               e = stage_q.pop_front();
               if (rsp_bus.radix !== e.radix || rsp_bus.stage_index !== e.stage_index ||
                   rsp_bus.last !== e.last || rsp_bus.error !== e.error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("stage mismatch: exp r=%0d i=%0d l=%0d e=%0d,",
                              e.radix, e.stage_index, e.last, e.error,
                              " got r=%0d i=%0d l=%0d e=%0d", rsp_bus.radix,
                              rsp_bus.stage_index, rsp_bus.last, rsp_bus.error);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("fft_radix_planner verification failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.length = '0;
      rsp_bus.ready  = 1'b0;
      cycles         = 0;
      mismatches     = 0;
      merge_lim      = 64'(MERGE_LIMIT_RST);
      lead_floor     = 64'(LEAD_MIN_RST);
      snd_idle       = 28;
      rcv_idle       = 61;
      plan_rows = '{
         '{32'd0,          1'b1, 32'd0,     1'b1},
         '{32'd1,          1'b1, 32'd0,     1'b1},
         '{32'd2,          1'b1, 32'd2,     1'b0},
         '{32'd3,          1'b1, 32'd3,     1'b0},
         '{32'd32,         1'b1, 32'd32,    1'b0},
         '{32'd65521,      1'b1, 32'd65521, 1'b0},
         '{32'hFFFF_FFFF,  1'b0, 32'd0,     1'b0},
         '{32'h8000_0000,  1'b0, 32'd0,     1'b0},
         '{32'd3486784401, 1'b0, 32'd0,     1'b0},
         '{32'd9699690,    1'b0, 32'd0,     1'b0},
         '{32'd720720,     1'b0, 32'd0,     1'b0},
         '{32'd96,         1'b0, 32'd0,     1'b0},
         '{32'd8633,       1'b0, 32'd0,     1'b0},
         '{32'd6,          1'b0, 32'd0,     1'b0},
         '{32'd1024,       1'b0, 32'd0,     1'b0},
         '{32'd30030,      1'b0, 32'd0,     1'b0},
         '{32'h5555_5555,  1'b0, 32'd0,     1'b0},
         '{32'd4,          1'b0, 32'd0,     1'b0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan_rows[k])
         send_length(plan_rows[k].length, plan_rows[k].typed, plan_rows[k].radix,
                     plan_rows[k].error);
      drain();
      random_phase(16'd65535, 16'd2,     28, 61, 20);
      random_phase(16'd2,     16'd65535, 61, 28, 20);
      // merge limit below two keeps every prime separate
      random_phase(16'd1,     16'd100,   61, 28, 15);
      random_phase(16'd0,     16'd0,     61, 28, 10);
      random_phase(CSR_W'($urandom_range(2, 600)), CSR_W'($urandom_range(2, 300)),
                   0, 0, 20);
      random_phase(16'd32,    16'd16,    0, 0, 15);
      if (mismatches == 0) begin
         $display("fft_radix_planner verification clean");
      end else begin
         $display("fft_radix_planner verification failed");
      end
      $finish;
   end

endmodule

FILE: fft_radix_planner.f
hw/rtl/frp_pkg.sv
hw/rtl/frp_req_if.sv
hw/rtl/frp_rsp_if.sv
hw/rtl/frp_ctrl.sv
hw/rtl/frp_dpath.sv
hw/rtl/fft_radix_planner.sv
tb/sv/testbench.sv
